// ----- rtl/sfc_pkg.sv -----
// ---------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants for the sphere/frustum cull block.
// ---------------------------------------------------------------------------
package sfc_pkg;

  // Frustum planes and their register map
  localparam int NUM_PLANES   = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  // Item field widths
  localparam int COORD_W      = 16;
  localparam int RADIUS_W     = 15;
  localparam int CULL_W       = 32;
  localparam int WORD_IDX_W   = 10;

  // Plane test accumulator: three Q17.14 products plus (d + r) scaled by 2^14
  localparam int PROD_W       = 2 * COORD_W;
  localparam int DR_W         = COORD_W + 1;
  localparam int NORM_FRAC    = 14;
  localparam int ACC_W        = PROD_W + 3;

  // Default sizes
  localparam int DEF_BITS_PER_WORD = 32;
  localparam int DEF_MAX_WORDS     = 1024;

  // One plane register: nx in the low 16 bits, d in the top 16 bits
  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } plane_t;

  // Item leaving the input register towards the packer
  typedef struct packed {
    logic adv;     // item moves on this cycle
    logic culled;  // any plane rejects the sphere
    logic last;    // final sphere of the batch
  } sfc_item_t;

endpackage

// ----- rtl/sfc_plane_test.sv -----
// ---------------------------------------------------------------------------
// sfc_plane_test
// Exact test of one sphere against one plane: n.c + d < -r.
// ---------------------------------------------------------------------------
module sfc_plane_test
  import sfc_pkg::*;
(
  input  plane_t                     plane,
  input  logic signed [COORD_W-1:0]  center_x,
  input  logic signed [COORD_W-1:0]  center_y,
  input  logic signed [COORD_W-1:0]  center_z,
  input  logic        [RADIUS_W-1:0] radius,
  output logic                       reject
);

  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [PROD_W-1:0] pz;
  logic        [DR_W-1:0]   dr;
  logic        [ACC_W-1:0]  acc;

  // Products in Q17.14
  assign px = plane.nx * center_x;
  assign py = plane.ny * center_y;
  assign pz = plane.nz * center_z;

  // Fold the radius into the offset: n.c + (d + r) * 2^14 < 0
  assign dr = {plane.d[COORD_W-1], plane.d} + {{(DR_W-RADIUS_W){1'b0}}, radius};

  assign acc = {{(ACC_W-PROD_W){px[PROD_W-1]}}, px}
             + {{(ACC_W-PROD_W){py[PROD_W-1]}}, py}
             + {{(ACC_W-PROD_W){pz[PROD_W-1]}}, pz}
             + {{(ACC_W-DR_W-NORM_FRAC){dr[DR_W-1]}}, dr, {NORM_FRAC{1'b0}}};

  // Negative sum: sphere wholly outside this plane
  assign reject = acc[ACC_W-1];

endmodule

// ----- rtl/sfc_packer.sv -----
// ---------------------------------------------------------------------------
// sfc_packer
// Packs cull flags LSB-first into words and holds the result register.
// ---------------------------------------------------------------------------
module sfc_packer
  import sfc_pkg::*;
#(
  parameter int BITS_PER_WORD = DEF_BITS_PER_WORD,
  parameter int MAX_WORDS     = DEF_MAX_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfc_item_t             item,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [CULL_W-1:0]     out_cull_bits,
  output logic [WORD_IDX_W-1:0] out_word_index,
  output logic                  out_last_word
);

  localparam int POS_W = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
  localparam int CNT_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [BITS_PER_WORD-1:0] pend_r, pend_nxt, pend_set;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt, cnt_inc;
  logic                     emit;

  logic                     out_valid_r, out_valid_nxt;
  logic [CULL_W-1:0]        cull_r;
  logic [WORD_IDX_W-1:0]    widx_r;
  logic                     lastw_r;

  logic [BITS_PER_WORD+CULL_W-1:0] cull_ext;
  logic [CNT_W+WORD_IDX_W-1:0]     cnt_ext;

  // Merge this item's flag into the word
  always_comb begin
    pend_set        = pend_r;
    pend_set[pos_r] = pend_r[pos_r] | item.culled;
  end

  assign emit    = item.last || (pos_r == POS_W'(BITS_PER_WORD - 1));
  assign cnt_inc = (cnt_r == CNT_W'(MAX_WORDS - 1)) ? '0 : cnt_r + 1'b1;

  // Word state update
  always_comb begin
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    if (item.adv) begin
      if (emit) begin
        pend_nxt = '0;
        pos_nxt  = '0;
        cnt_nxt  = item.last ? '0 : cnt_inc;
      end else begin
        pend_nxt = pend_set;
        pos_nxt  = pos_r + 1'b1;
      end
    end
  end

  // Fit the word and index to the result fields
  assign cull_ext = {{CULL_W{1'b0}}, pend_set};
  assign cnt_ext  = {{WORD_IDX_W{1'b0}}, cnt_r};

  // Result register: loads on emit, frees once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item.adv && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item.adv && emit) begin
      cull_r  <= cull_ext[CULL_W-1:0];
      widx_r  <= cnt_ext[WORD_IDX_W-1:0];
      lastw_r <= item.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cull_bits  = cull_r;
  assign out_word_index = widx_r;
  assign out_last_word  = lastw_r;

endmodule

// ----- rtl/sphere_frustum_cull.sv -----
// ---------------------------------------------------------------------------
// sphere_frustum_cull
// Sphere versus six-plane frustum cull with packed result words.
// ---------------------------------------------------------------------------
// One sphere is taken per clock while the output does not stall. Each result
// word passes the input register, where its closing sphere sits while the six
// exact plane tests (three 16x16 products and one add per plane) and the bit
// packing run, and then the result register. A stall on the output holds the
// input register and, behind it, the input channel. A word is emitted every
// BITS_PER_WORD spheres, or early at a sphere marked last_sphere, which also
// resets the word index. Unused cfg_ indexes are ignored. The user must write
// planes through the cfg_ port only while no sphere is in flight (not enforced).
module sphere_frustum_cull
  import sfc_pkg::*;
#(
  parameter int BITS_PER_WORD = DEF_BITS_PER_WORD,
  parameter int MAX_WORDS     = DEF_MAX_WORDS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  // sphere items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COORD_W-1:0]   in_center_x,
  input  logic signed [COORD_W-1:0]   in_center_y,
  input  logic signed [COORD_W-1:0]   in_center_z,
  input  logic        [RADIUS_W-1:0]  in_radius,
  input  logic                        in_last_sphere,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [CULL_W-1:0]           out_cull_bits,
  output logic [WORD_IDX_W-1:0]       out_word_index,
  output logic                        out_last_word
);

  plane_t                    plane_r [NUM_PLANES];

  logic                      s1_valid_r, s1_valid_nxt;
  logic signed [COORD_W-1:0] s1_cx_r, s1_cy_r, s1_cz_r;
  logic [RADIUS_W-1:0]       s1_rad_r;
  logic                      s1_last_r;

  logic                      out_free;
  logic                      in_take;
  logic [NUM_PLANES-1:0]     reject;
  sfc_item_t                 item;

  // Plane registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          plane_r[i] <= plane_t'(cfg_wdata);
        end
      end
    end
  end

  // Handshake: the input register moves whenever the result register can load
  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_valid_r && out_free) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cx_r   <= in_center_x;
      s1_cy_r   <= in_center_y;
      s1_cz_r   <= in_center_z;
      s1_rad_r  <= in_radius;
      s1_last_r <= in_last_sphere;
    end
  end

  // Six plane tests side by side
  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
    sfc_plane_test u_test (
      .plane    (plane_r[g]),
      .center_x (s1_cx_r),
      .center_y (s1_cy_r),
      .center_z (s1_cz_r),
      .radius   (s1_rad_r),
      .reject   (reject[g])
    );
  end

  assign item.adv    = s1_valid_r && out_free;
  assign item.culled = |reject;
  assign item.last   = s1_last_r;

  // Bit packing and result register
  sfc_packer #(
    .BITS_PER_WORD (BITS_PER_WORD),
    .MAX_WORDS     (MAX_WORDS)
  ) u_packer (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_cull_bits  (out_cull_bits),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

  // Checks
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (item.adv && s1_last_r) |=> (out_valid && out_last_word))
    else $error("last sphere did not close a word");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (item.adv && s1_last_r && out_free) |=> (out_word_index <= WORD_IDX_W'(MAX_WORDS - 1)))
    else $error("word index beyond range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

endmodule

// ----- tb/sv/sfc_cull_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sfc_cull_checker
// Watches the plane writes and both item channels of the sphere cull block,
// predicts every packed cull word and compares it field by field.
// ---------------------------------------------------------------------------
module sfc_cull_checker
  import sfc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [COORD_W-1:0]  in_center_x,
  input  logic signed [COORD_W-1:0]  in_center_y,
  input  logic signed [COORD_W-1:0]  in_center_z,
  input  logic [RADIUS_W-1:0]        in_radius,
  input  logic                       in_last_sphere,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [CULL_W-1:0]          out_cull_bits,
  input  logic [WORD_IDX_W-1:0]      out_word_index,
  input  logic                       out_last_word,
  output int                         fail_count,
  output int                         words_due
);

  localparam int     WORD_BITS  = DEF_BITS_PER_WORD;
  localparam int     WORD_SLOTS = DEF_MAX_WORDS;
  localparam longint Q14_ONE    = longint'(1) << NORM_FRAC;

  typedef struct packed {
    logic [CULL_W-1:0]     bits;
    logic [WORD_IDX_W-1:0] idx;
    logic                  last;
  } cull_word_t;

  // Shadow copy of the frustum and of the packer
  plane_t            frustum [NUM_PLANES];
  logic [CULL_W-1:0] gathered;
  int                fill;
  int                next_word;
  int                words_seen;
  cull_word_t        expected_words [$];

  // Exact plane test: n.c + d < -r, everything scaled to Q.14
  function automatic logic outside_plane(plane_t pl, logic signed [COORD_W-1:0] cx,
                                         logic signed [COORD_W-1:0] cy,
                                         logic signed [COORD_W-1:0] cz,
                                         logic [RADIUS_W-1:0] r);
    longint level;
    longint reach;
    level = longint'($signed(pl.nx)) * longint'(cx)
          + longint'($signed(pl.ny)) * longint'(cy)
          + longint'($signed(pl.nz)) * longint'(cz)
          + longint'($signed(pl.d)) * Q14_ONE;
    reach = longint'(r) * Q14_ONE;
    return level < -reach;
  endfunction

  function automatic logic sphere_culled(logic signed [COORD_W-1:0] cx,
                                         logic signed [COORD_W-1:0] cy,
                                         logic signed [COORD_W-1:0] cz,
                                         logic [RADIUS_W-1:0] r);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_PLANES; i++)
      if (outside_plane(frustum[i], cx, cy, cz, r)) hit = 1'b1;
    return hit;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t word %0d: %s got %0h want %0h", $realtime, words_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    cull_word_t want;
    if (!rst_n) begin
      foreach (frustum[i]) frustum[i] = '0;
      gathered   = '0;
      fill       = 0;
      next_word  = 0;
      words_seen = 0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      // result side: oldest expectation first
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report("word with none expected, cull_bits", out_cull_bits, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_cull_bits !== want.bits) report("cull_bits", out_cull_bits, want.bits);
          if (out_word_index !== want.idx) report("word_index", out_word_index, want.idx);
          if (out_last_word !== want.last) report("last_word", out_last_word, want.last);
        end
        words_seen++;
      end

      // sphere side: pack one cull bit, close the word when full or last
      if (in_valid && !in_stall) begin
        if (sphere_culled(in_center_x, in_center_y, in_center_z, in_radius))
          gathered[fill] = 1'b1;
        fill++;
        if (in_last_sphere || fill >= WORD_BITS) begin
          want.bits = gathered;
          want.idx  = WORD_IDX_W'(next_word);
          want.last = in_last_sphere;
          expected_words.push_back(want);
          gathered  = '0;
          fill      = 0;
          next_word = in_last_sphere ? 0 : (next_word + 1) % WORD_SLOTS;
        end
      end

      // plane writes; unused indexes change nothing
      if (cfg_we && cfg_index < NUM_PLANES) frustum[cfg_index] = cfg_wdata;
    end
    words_due <= expected_words.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the sphere cull block: plane loads, directed edge spheres and
// random sphere streams under several idle and stall mixes, then the verdict.
// ---------------------------------------------------------------------------
module tb_top
  import sfc_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 96;
  localparam int LONG_ITEMS  = 4 * DEF_BITS_PER_WORD + 6;

  typedef enum int {PL_BOX, PL_RAW, PL_TILTED, PL_EXTREME} plane_mix_e;

  logic                      clk;
  logic                      rst_n          = 1'b0;
  logic                      cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index      = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata      = '0;
  logic                      in_valid       = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_center_x    = '0;
  logic signed [COORD_W-1:0] in_center_y    = '0;
  logic signed [COORD_W-1:0] in_center_z    = '0;
  logic [RADIUS_W-1:0]       in_radius      = '0;
  logic                      in_last_sphere = 1'b0;
  logic                      out_valid;
  logic                      out_stall      = 1'b0;
  logic [CULL_W-1:0]         out_cull_bits;
  logic [WORD_IDX_W-1:0]     out_word_index;
  logic                      out_last_word;

  int     fail_count;
  int     words_due;
  int     idle_pct  = 0;
  int     stall_pct = 0;
  int     last_pct  = 0;
  int     box_ext   = 100;
  int     idle_tab [4] = '{0, 76, 0, 9};
  int     stall_tab[4] = '{0, 0, 76, 9};
  plane_t frustum_plan [NUM_PLANES];

  sphere_frustum_cull dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_center_x, .in_center_y, .in_center_z,
    .in_radius, .in_last_sphere,
    .out_valid, .out_stall, .out_cull_bits, .out_word_index, .out_last_word
  );

  sfc_cull_checker word_check (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_center_x, .in_center_y, .in_center_z,
    .in_radius, .in_last_sphere,
    .out_valid, .out_stall, .out_cull_bits, .out_word_index, .out_last_word,
    .fail_count, .words_due
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic plane_t make_plane(int nx, int ny, int nz, int d);
    plane_t pl;
    pl.nx = nx[COORD_W-1:0];
    pl.ny = ny[COORD_W-1:0];
    pl.nz = nz[COORD_W-1:0];
    pl.d  = d[COORD_W-1:0];
    return pl;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(3))
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(3))
      0:       return int'($urandom_range(65535)) - 32768;
      1:       return int'($urandom_range(4095)) - 2048;
      2:       return pick_extreme();
      default: return ($urandom_range(1) ? 1 : -1) *
                      (box_ext + int'($urandom_range(600)) - 300);
    endcase
  endfunction

  function automatic int rand_radius();
    case ($urandom_range(6))
      4:       return int'($urandom_range(32767));
      5:       return 0;
      6:       return 32767;
      default: return int'($urandom_range(300));
    endcase
  endfunction

  // axis-aligned cube of half-size ext around the origin
  task automatic set_box(int ext);
    box_ext = ext;
    frustum_plan[0] = make_plane( 16384, 0, 0, ext);
    frustum_plan[1] = make_plane(-16384, 0, 0, ext);
    frustum_plan[2] = make_plane(0,  16384, 0, ext);
    frustum_plan[3] = make_plane(0, -16384, 0, ext);
    frustum_plan[4] = make_plane(0, 0,  16384, ext);
    frustum_plan[5] = make_plane(0, 0, -16384, ext);
  endtask

  task automatic set_planes(plane_mix_e mix);
    case (mix)
      PL_BOX: set_box(int'($urandom_range(4000)));
      PL_RAW:
        foreach (frustum_plan[i]) frustum_plan[i] = {$urandom, $urandom};
      PL_TILTED:
        foreach (frustum_plan[i])
          frustum_plan[i] = make_plane(int'($urandom_range(32767)) - 16384,
                                       int'($urandom_range(32767)) - 16384,
                                       int'($urandom_range(32767)) - 16384,
                                       int'($urandom_range(8000)));
      default:
        foreach (frustum_plan[i])
          frustum_plan[i] = make_plane(pick_extreme(), pick_extreme(),
                                       pick_extreme(), pick_extreme());
    endcase
  endtask

  // every index, the unused ones with junk that must be ignored
  task automatic write_frustum();
    for (int idx = 0; idx < (1 << CFG_IDX_W); idx++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[CFG_IDX_W-1:0];
      cfg_wdata <= (idx < NUM_PLANES) ? CFG_DATA_W'(frustum_plan[idx]) : {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every word is out and the pipe has emptied
  task automatic drain_words();
    stall_pct = 0;
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_sphere(int cx, int cy, int cz, int r, bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_center_x    <= cx[COORD_W-1:0];
    in_center_y    <= cy[COORD_W-1:0];
    in_center_z    <= cz[COORD_W-1:0];
    in_radius      <= r[RADIUS_W-1:0];
    in_last_sphere <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    int         k;
    int         mode;
    plane_mix_e mix;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // planes still at reset: nothing is culled
    send_sphere(0, 0, 0, 0, 1'b0);
    send_sphere(-32768, -32768, -32768, 32767, 1'b1);

    // cube of half-size 100: spheres just touching and just outside a face
    drain_words();
    set_box(100);
    write_frustum();
    send_sphere(-150, 0, 0, 50, 1'b0);
    send_sphere(-151, 0, 0, 50, 1'b0);
    send_sphere(150, 0, 0, 50, 1'b0);
    send_sphere(0, 151, 0, 50, 1'b0);
    send_sphere(0, 0, -100, 0, 1'b0);
    send_sphere(0, 0, -101, 0, 1'b0);
    send_sphere(0, 0, 101, 0, 1'b1);

    // widest plane values against the corners of the coordinate range
    drain_words();
    frustum_plan[0] = make_plane(32767, 32767, 32767, -32768);
    frustum_plan[1] = make_plane(-32768, -32768, -32768, -32768);
    frustum_plan[2] = make_plane(-1, -1, -1, -1);
    frustum_plan[3] = make_plane(32767, -32768, 32767, 32767);
    frustum_plan[4] = make_plane(-32768, 32767, -32768, 32767);
    frustum_plan[5] = make_plane(0, 0, 0, 0);
    write_frustum();
    for (k = 0; k < 8; k++)
      send_sphere(k[0] ? 32767 : -32768, k[1] ? 32767 : -32768,
                  k[2] ? 32767 : -32768, k[0] ? 0 : 32767, 1'b0);
    send_sphere(0, 0, 0, 32767, 1'b1);

    // random streams, a new plane mix per phase and a new handshake mix every second phase
    for (int ph = 0; ph < 8; ph++) begin
      drain_words();
      mix = plane_mix_e'(ph % 4);
      set_planes(mix);
      write_frustum();
      mode      = (ph / 2) % 4;
      idle_pct  = idle_tab[mode];
      stall_pct = stall_tab[mode];
      last_pct  = (ph % 2) ? 25 : 2;
      repeat (PHASE_ITEMS)
        send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius(),
                    $urandom_range(99) < last_pct);
    end

    // one long batch spanning several full words and a partial one
    drain_words();
    set_box(int'($urandom_range(2000)));
    write_frustum();
    idle_pct = 0;
    for (k = 0; k < LONG_ITEMS; k++)
      send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius(), 1'b0);
    send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius(), 1'b1);

    drain_words();
    if (fail_count == 0 && words_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sfc_pkg.sv
rtl/sfc_plane_test.sv
rtl/sfc_packer.sv
rtl/sphere_frustum_cull.sv
tb/sv/sfc_cull_checker.sv
tb/sv/tb_top.sv
